>>> design/htm_pkg.sv
// shared types, constants and sector table for the hall transition monitor
`timescale 1ns / 1ps

package htm_pkg;

  // configuration register indexes
  localparam logic CFG_SETTLE = 1'b0;
  localparam logic CFG_PERIOD = 1'b1;

  // register reset values
  localparam logic [3:0]  SETTLE_RESET = 4'd3;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  // hall codes that carry no sector
  localparam logic [2:0] HALL_ALL_LOW  = 3'b000;
  localparam logic [2:0] HALL_ALL_HIGH = 3'b111;

  // report kinds
  typedef enum logic [2:0] {
    EV_PERIODIC = 3'd0,
    EV_STEP     = 3'd1,
    EV_INVALID  = 3'd2,
    EV_SKIP     = 3'd3,
    EV_START    = 3'd4,
    EV_CLEARED  = 3'd5
  } ev_kind_t;

  // input word
  typedef struct packed {
    logic [2:0] hall_bits;
    logic       clear;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [2:0]  hall_state;
    logic [2:0]  sector;
    logic        sector_ok;
    ev_kind_t    event_kind;
    logic [31:0] step_count;
    logic [31:0] rise_count;
    logic [31:0] invalid_count;
    logic [31:0] skip_count;
    logic [31:0] elapsed_ticks;
    logic [31:0] now_ticks;
  } out_word_t;

  // hall state to electrical sector, zero for the invalid codes
  function automatic logic [2:0] sector_of(input logic [2:0] s);
    logic [2:0] sec;
    case (s)
      3'b001:  sec = 3'd0;
      3'b101:  sec = 3'd1;
      3'b100:  sec = 3'd2;
      3'b110:  sec = 3'd3;
      3'b010:  sec = 3'd4;
      3'b011:  sec = 3'd5;
      default: sec = 3'd0;
    endcase
    return sec;
  endfunction

  function automatic logic hall_valid(input logic [2:0] s);
    return (s != HALL_ALL_LOW) && (s != HALL_ALL_HIGH);
  endfunction

endpackage

>>> design/hall_transition_monitor_top.sv
// top level of the hall transition monitor: input register, config, tracker, result queue
// flow: a word is taken into the input register, then processed by the tracker, which waits
//   while the result queue is full; its report, if any, is queued and then shown on out_data
// throughput: one word per cycle while the two-entry result queue has room; input stalls
//   when both entries hold reports that wait for out_ready
// reset: synchronous active low; clears tracker state, counters, queue and restores
//   settle_samples to 3 and report_period to 1000
`timescale 1ns / 1ps

module hall_transition_monitor_top #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  htm_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output htm_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import htm_pkg::*;

  logic [3:0]  settle_r;
  logic [15:0] period_r;

  logic        in_valid_r;
  in_word_t    in_word_r;

  out_word_t   q_r [2];
  logic        wr_ptr_r, rd_ptr_r;
  logic [1:0]  q_cnt_r, q_cnt_nxt;

  logic        fire;
  logic        pop;
  logic        push;
  logic        res_valid;
  out_word_t   res_word;

  // handshakes
  assign pop      = out_valid && out_ready;
  assign fire     = in_valid_r && ((q_cnt_r != 2'd2) || pop);
  assign in_ready = !in_valid_r || fire;
  assign push     = res_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= SETTLE_RESET;
      period_r <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SETTLE: settle_r <= cfg_data[3:0];
        CFG_PERIOD: period_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  htm_track #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (fire),
    .in_word        (in_word_r),
    .settle_samples (settle_r),
    .report_period  (period_r),
    .res_valid      (res_valid),
    .res_word       (res_word)
  );

  // result queue
  always_comb begin
    q_cnt_nxt = q_cnt_r;
    case ({push, pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= res_word;
    end
  end

  assign out_valid = q_cnt_r != 2'd0;
  assign out_data  = q_r[rd_ptr_r];

endmodule

>>> design/htm_track.sv
// hall state tracker: debounce, transition classification, counters and report build
`timescale 1ns / 1ps

module htm_track #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  htm_pkg::in_word_t in_word,
  input  logic [3:0]        settle_samples,
  input  logic [15:0]       report_period,
  output logic              res_valid,
  output htm_pkg::out_word_t res_word
);
  import htm_pkg::*;

  // tracker state
  logic [2:0]             acc_r, acc_nxt;
  logic                   known_r, known_nxt;
  logic [2:0]             cand_r, cand_nxt;
  logic [3:0]             run_r, run_nxt;
  logic [31:0]            tick_r, tick_nxt;
  logic [31:0]            last_step_r, last_step_nxt;
  logic [31:0]            last_rep_r, last_rep_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r   [4];
  logic [COUNT_WIDTH-1:0] cnt_nxt [4];
  logic [31:0]            cnt_out [4];

  logic [31:0] now;
  logic [3:0]  settle_eff;
  logic        hit;
  logic [2:0]  diff;
  logic        emit;
  ev_kind_t    kind;
  logic [31:0] elapsed;

  assign now        = tick_r + 32'd1;
  assign settle_eff = (settle_samples == 4'd0) ? 4'd1 : settle_samples;

  // per-word update
  always_comb begin
    acc_nxt       = acc_r;
    known_nxt     = known_r;
    cand_nxt      = cand_r;
    run_nxt       = run_r;
    tick_nxt      = now;
    last_step_nxt = last_step_r;
    last_rep_nxt  = last_rep_r;
    for (int i = 0; i < 4; i++) begin
      cnt_nxt[i] = cnt_r[i];
    end
    emit    = 1'b0;
    kind    = EV_PERIODIC;
    elapsed = 32'd0;
    hit     = 1'b0;
    diff    = 3'd0;

    if (in_word.clear) begin
      // clear wins over everything else
      for (int i = 0; i < 4; i++) begin
        cnt_nxt[i] = '0;
      end
      last_step_nxt = now;
      acc_nxt       = in_word.hall_bits;
      cand_nxt      = in_word.hall_bits;
      run_nxt       = 4'd1;
      known_nxt     = 1'b1;
      emit          = 1'b1;
      kind          = EV_CLEARED;
    end else begin
      // debounce run
      if (in_word.hall_bits == cand_r) begin
        run_nxt = (run_r == 4'd15) ? 4'd15 : run_r + 4'd1;
      end else begin
        cand_nxt = in_word.hall_bits;
        run_nxt  = 4'd1;
      end
      hit  = run_nxt >= settle_eff;
      diff = acc_r ^ cand_nxt;

      if (hit && !known_r) begin
        // first acceptance after reset
        known_nxt = 1'b1;
        acc_nxt   = cand_nxt;
        if (!hall_valid(cand_nxt)) begin
          cnt_nxt[2] = cnt_r[2] + COUNT_WIDTH'(1);
        end
        emit = 1'b1;
        kind = EV_START;
      end else if (hit && (cand_nxt != acc_r)) begin
        // accepted change, classify it
        elapsed = now - last_step_r;
        acc_nxt = cand_nxt;
        emit    = 1'b1;
        if (!hall_valid(cand_nxt)) begin
          cnt_nxt[2] = cnt_r[2] + COUNT_WIDTH'(1);
          kind       = EV_INVALID;
        end else if (hall_valid(acc_r) && $onehot(diff)) begin
          cnt_nxt[0] = cnt_r[0] + COUNT_WIDTH'(1);
          if (!acc_r[0] && cand_nxt[0]) begin
            cnt_nxt[1] = cnt_r[1] + COUNT_WIDTH'(1);
          end
          last_step_nxt = now;
          kind          = EV_STEP;
        end else begin
          cnt_nxt[3] = cnt_r[3] + COUNT_WIDTH'(1);
          kind       = EV_SKIP;
        end
      end else if (known_r && ((now - last_rep_r) >= {16'd0, report_period})) begin
        // quiet for a full report period
        emit    = 1'b1;
        kind    = EV_PERIODIC;
        elapsed = now - last_step_r;
      end
    end

    if (emit) begin
      last_rep_nxt = now;
    end
  end

  // counters onto the 32-bit report fields
  for (genvar g = 0; g < 4; g++) begin : g_cnt_out
    if (COUNT_WIDTH >= 32) begin : g_trunc
      assign cnt_out[g] = cnt_nxt[g][31:0];
    end else begin : g_ext
      assign cnt_out[g] = {{(32 - COUNT_WIDTH){1'b0}}, cnt_nxt[g]};
    end
  end

  // result word
  always_comb begin
    res_valid              = fire && emit;
    res_word.hall_state    = acc_nxt;
    res_word.sector        = sector_of(acc_nxt);
    res_word.sector_ok     = hall_valid(acc_nxt);
    res_word.event_kind    = kind;
    res_word.step_count    = cnt_out[0];
    res_word.rise_count    = cnt_out[1];
    res_word.invalid_count = cnt_out[2];
    res_word.skip_count    = cnt_out[3];
    res_word.elapsed_ticks = elapsed;
    res_word.now_ticks     = now;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 3'd0;
      known_r     <= 1'b0;
      cand_r      <= 3'd0;
      run_r       <= 4'd0;
      tick_r      <= 32'd0;
      last_step_r <= 32'd0;
      last_rep_r  <= 32'd0;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (fire) begin
      acc_r       <= acc_nxt;
      known_r     <= known_nxt;
      cand_r      <= cand_nxt;
      run_r       <= run_nxt;
      tick_r      <= tick_nxt;
      last_step_r <= last_step_nxt;
      last_rep_r  <= last_rep_nxt;
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
    end
  end

endmodule
